// File: design/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg: shared types and constants of the line follow steering block
// Register map, register file type, line tracking state and drive mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lfs_pkg;

    // minimum spacing of accepted camera reports in ms
    localparam logic [31:0] SCAN_MS = 32'd50;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X     = 3'd0,
        REG_GAIN_OFFSET  = 3'd1,
        REG_GAIN_ANGLE   = 3'd2,
        REG_BASE_SPEED   = 3'd3,
        REG_SHARP_SPEED  = 3'd4,
        REG_SHARP_LIMIT  = 3'd5,
        REG_SPIN_SPEED   = 3'd6,
        REG_LOST_TIMEOUT = 3'd7
    } cfg_reg_t;

    localparam int CFG_DATA_W = 16;

    // drive mode codes as seen on the result channel
    localparam logic [1:0] MODE_TRACK = 2'd0;
    localparam logic [1:0] MODE_PIVOT = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    // wheel speed limit
    localparam logic [6:0] SPEED_MAX = 7'd100;

    // line tracking state
    typedef enum logic [2:0] {
        LINE_NEVER = 3'b001,
        LINE_SEEN  = 3'b010,
        LINE_LOST  = 3'b100
    } line_state_t;

    // configuration register file contents
    typedef struct packed {
        logic        [9:0]  center_x;
        logic signed [15:0] gain_offset;
        logic signed [15:0] gain_angle;
        logic signed [7:0]  base_speed;
        logic signed [7:0]  sharp_speed;
        logic        [6:0]  sharp_turn_limit;
        logic        [6:0]  spin_speed;
        logic        [15:0] lost_timeout_ms;
    } cfg_t;

endpackage

`default_nettype wire

// File: design/lfs_cfg_regs.sv
// ----------------------------------------------------------------------------
// lfs_cfg_regs: configuration register file
// Eight registers written through an indexed write channel, reset to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module lfs_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lfs_pkg::CFG_DATA_W-1:0] cfg_data,
    output lfs_pkg::cfg_t                       cfg
);

    lfs_pkg::cfg_t cfg_reg;
    lfs_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (lfs_pkg::cfg_reg_t'(cfg_index))
                lfs_pkg::REG_CENTER_X:     cfg_next.center_x         = cfg_data[9:0];
                lfs_pkg::REG_GAIN_OFFSET:  cfg_next.gain_offset      = cfg_data;
                lfs_pkg::REG_GAIN_ANGLE:   cfg_next.gain_angle       = cfg_data;
                lfs_pkg::REG_BASE_SPEED:   cfg_next.base_speed       = cfg_data[7:0];
                lfs_pkg::REG_SHARP_SPEED:  cfg_next.sharp_speed      = cfg_data[7:0];
                lfs_pkg::REG_SHARP_LIMIT:  cfg_next.sharp_turn_limit = cfg_data[6:0];
                lfs_pkg::REG_SPIN_SPEED:   cfg_next.spin_speed       = cfg_data[6:0];
                lfs_pkg::REG_LOST_TIMEOUT: cfg_next.lost_timeout_ms  = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_x         <= 10'd160;
            cfg_reg.gain_offset      <= 16'sd64;
            cfg_reg.gain_angle       <= 16'sd64;
            cfg_reg.base_speed       <= 8'sd40;
            cfg_reg.sharp_speed      <= 8'sd25;
            cfg_reg.sharp_turn_limit <= 7'd30;
            cfg_reg.spin_speed       <= 7'd30;
            cfg_reg.lost_timeout_ms  <= 16'd2000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: design/lfs_steer.sv
// ----------------------------------------------------------------------------
// lfs_steer: tracking wheel speeds
// Q8.8 steering correction, speed select, clamp to +/-100 and rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module lfs_steer (
    input  wire lfs_pkg::cfg_t        cfg,
    input  wire logic        [9:0]    start_x,
    input  wire logic signed [7:0]    line_angle,
    output logic signed      [7:0]    left_speed,
    output logic signed      [7:0]    right_speed
);

    localparam logic signed [28:0] LIM_Q8 = 29'sd25600;
    // lim plus half an lsb of the integer part
    localparam logic [15:0] ROUND_OFS = 16'd25728;
    localparam logic [6:0] SPEED_MAX_8 = lfs_pkg::SPEED_MAX;

    logic signed [10:0] x_ofs;
    logic signed [26:0] prod_ofs;
    logic signed [23:0] prod_ang;
    logic signed [27:0] corr;
    logic        [7:0]  ang_abs;
    logic signed [7:0]  spd;
    logic signed [28:0] spd_q8;
    logic signed [28:0] sum_l;
    logic signed [28:0] sum_r;

    // clamp a q8.8 value to +/-100.0 and round halves upward
    function automatic logic signed [7:0] to_wheel(input logic signed [28:0] v);
        logic signed [28:0] c;
        logic        [15:0] u;
        begin
            if (v > LIM_Q8)
                c = LIM_Q8;
            else if (v < -LIM_Q8)
                c = -LIM_Q8;
            else
                c = v;
            u = c[15:0] + ROUND_OFS;
            return u[15:8] - {1'b0, SPEED_MAX_8};
        end
    endfunction

    always_comb begin
        x_ofs    = $signed({1'b0, start_x}) - $signed({1'b0, cfg.center_x});
        prod_ofs = cfg.gain_offset * x_ofs;
        prod_ang = cfg.gain_angle * line_angle;
        corr     = {prod_ofs[26], prod_ofs} + {{4{prod_ang[23]}}, prod_ang};

        ang_abs  = line_angle[7] ? (8'd0 - line_angle) : line_angle;
        spd      = (ang_abs > {1'b0, cfg.sharp_turn_limit}) ? cfg.sharp_speed : cfg.base_speed;
        spd_q8   = {{13{spd[7]}}, spd, 8'd0};

        sum_l    = spd_q8 + {corr[27], corr};
        sum_r    = spd_q8 - {corr[27], corr};
    end

    assign left_speed  = to_wheel(sum_l);
    assign right_speed = to_wheel(sum_r);

endmodule

`default_nettype wire

// File: design/line_follow_steering.sv
// ----------------------------------------------------------------------------
// line_follow_steering: differential drive steering from camera line reports
// Turns camera line reports into left and right wheel commands and a mode.
// ----------------------------------------------------------------------------
// Each input item is one camera report. A report is registered on entry and
// worked out from the input register, where it either drops out (it came less
// than 50 ms after the last accepted report) or produces exactly one result
// item in the output register, waiting in the input register while that one
// is full. One item per cycle is sustained while m_tready is high. The output
// register lets a new item enter while a result still waits for m_tready, and
// the path between the two registers holds the two gain multipliers, the
// correction add, the clamp and the 32-bit timestamp compares. While the line
// is seen the wheels run at speed +/- correction; once it is lost the robot
// pivots toward the side of the last seen angle for lost_timeout_ms, then
// stops. A line never seen gives a stop. Configuration writes are taken in
// any cycle and should only be made while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_steering (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // camera report items
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [55:0]                    s_tdata,  // now_ms[31:0], start_x[41:32],
                                                          // line_angle[49:42], zero pad
    input  wire logic                           s_tuser,  // line_seen
    // wheel command items
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [15:0]                         m_tdata,  // left_speed[7:0], right_speed[15:8]
    output logic [1:0]                          m_tuser,  // drive_mode
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lfs_pkg::CFG_DATA_W-1:0] cfg_data
);

    lfs_pkg::cfg_t cfg;

    // input register
    logic               in_valid_reg;
    logic               in_valid_next;
    logic [31:0]        now_reg;
    logic               seen_reg;
    logic [9:0]         start_x_reg;
    logic signed [7:0]  angle_reg;

    // tracking state
    logic [31:0]          last_scan_reg, last_scan_next;
    lfs_pkg::line_state_t lstate_reg, lstate_next;
    logic                 recovering_reg, recovering_next;
    logic [31:0]          lost_start_reg, lost_start_next;
    logic signed [7:0]    last_angle_reg, last_angle_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic signed [7:0]  left_reg, left_next;
    logic signed [7:0]  right_reg, right_next;
    logic [1:0]         mode_reg, mode_next;

    // datapath
    logic signed [7:0]  trk_left;
    logic signed [7:0]  trk_right;
    logic [31:0]        scan_gap;
    logic [31:0]        lost_gap;
    logic               gate_pass;
    logic               out_free;
    logic               retire;     // item leaves the input register
    logic               emit;       // item leaves with a result
    logic [6:0]         pivot_mag;

    lfs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfs_steer u_steer (
        .cfg         (cfg),
        .start_x     (start_x_reg),
        .line_angle  (angle_reg),
        .left_speed  (trk_left),
        .right_speed (trk_right)
    );

    // scan gate: too early reports drop out without touching any state
    assign scan_gap  = now_reg - last_scan_reg;
    assign gate_pass = (scan_gap >= lfs_pkg::SCAN_MS);

    // an item that produces a result needs room in the output register
    assign out_free  = !out_valid_reg || m_tready;
    assign retire    = in_valid_reg && (!gate_pass || out_free);
    assign emit      = in_valid_reg && gate_pass && out_free;
    assign s_tready  = !in_valid_reg || retire;

    assign pivot_mag = (cfg.spin_speed > lfs_pkg::SPEED_MAX) ? lfs_pkg::SPEED_MAX
                                                             : cfg.spin_speed;

    always_comb begin
        last_scan_next  = last_scan_reg;
        lstate_next     = lstate_reg;
        recovering_next = recovering_reg;
        lost_start_next = lost_start_reg;
        last_angle_next = last_angle_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        mode_next       = mode_reg;
        lost_gap        = 32'd0;

        if (emit) begin
            last_scan_next = now_reg;

            // line state update
            if (seen_reg)
                lstate_next = lfs_pkg::LINE_SEEN;
            else if (lstate_reg != lfs_pkg::LINE_NEVER)
                lstate_next = lfs_pkg::LINE_LOST;

            case (lstate_next)
                lfs_pkg::LINE_SEEN: begin
                    left_next       = trk_left;
                    right_next      = trk_right;
                    mode_next       = lfs_pkg::MODE_TRACK;
                    recovering_next = 1'b0;
                    last_angle_next = angle_reg;
                end
                lfs_pkg::LINE_LOST: begin
                    // first lost report starts the pivot timer at zero
                    if (!recovering_reg) begin
                        recovering_next = 1'b1;
                        lost_start_next = now_reg;
                    end else begin
                        lost_gap = now_reg - lost_start_reg;
                    end
                    if (lost_gap < {16'd0, cfg.lost_timeout_ms}) begin
                        mode_next = lfs_pkg::MODE_PIVOT;
                        if (!last_angle_reg[7] && (last_angle_reg != 8'sd0)) begin
                            left_next  = $signed({1'b0, pivot_mag});
                            right_next = 8'sd0 - $signed({1'b0, pivot_mag});
                        end else begin
                            left_next  = 8'sd0 - $signed({1'b0, pivot_mag});
                            right_next = $signed({1'b0, pivot_mag});
                        end
                    end else begin
                        mode_next  = lfs_pkg::MODE_STOP;
                        left_next  = 8'sd0;
                        right_next = 8'sd0;
                    end
                end
                default: begin
                    // line never seen
                    mode_next  = lfs_pkg::MODE_STOP;
                    left_next  = 8'sd0;
                    right_next = 8'sd0;
                end
            endcase
        end
    end

    always_comb begin
        if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (retire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_scan_reg  <= 32'd0;
            lstate_reg     <= lfs_pkg::LINE_NEVER;
            recovering_reg <= 1'b0;
            lost_start_reg <= 32'd0;
            last_angle_reg <= 8'sd0;
        end else begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            last_scan_reg  <= last_scan_next;
            lstate_reg     <= lstate_next;
            recovering_reg <= recovering_next;
            lost_start_reg <= lost_start_next;
            last_angle_reg <= last_angle_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            now_reg     <= s_tdata[31:0];
            start_x_reg <= s_tdata[41:32];
            angle_reg   <= s_tdata[49:42];
            seen_reg    <= s_tuser;
        end
        left_reg  <= left_next;
        right_reg <= right_next;
        mode_reg  <= mode_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {right_reg, left_reg};
    assign m_tuser  = mode_reg;

endmodule

`default_nettype wire

// File: design/lfs_checker.sv
// ----------------------------------------------------------------------------
// lfs_checker: port level checks of the line follow steering block
// Result channel holding rules and consistency of wheel commands with mode.
// ----------------------------------------------------------------------------
`default_nettype none

module lfs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a stop drives both wheels to zero
    a_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == lfs_pkg::MODE_STOP) |-> (m_tdata == 16'd0))
        else $error("stop with nonzero wheels");

    // a pivot runs the wheels at opposite speeds
    a_pivot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == lfs_pkg::MODE_PIVOT) |->
            ((m_tdata[15:8] + m_tdata[7:0]) == 8'd0))
        else $error("pivot wheels not opposite");

    // wheel commands stay within +/-100 and mode is a known code
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[7:0]) <= 8'sd100) && ($signed(m_tdata[7:0]) >= -8'sd100)
            && ($signed(m_tdata[15:8]) <= 8'sd100) && ($signed(m_tdata[15:8]) >= -8'sd100)
            && (m_tuser != 2'd3))
        else $error("wheel command or mode out of range");

endmodule

bind line_follow_steering lfs_checker u_lfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
